>>> design/bdcs_pkg.sv
// Shared types, constants and register codes for the button debounce channel stepper.
package bdcs_pkg;

    // Field widths
    localparam int LEVEL_W  = 8;
    localparam int TIME_W   = 32;
    localparam int CHAN_W   = 6;
    localparam int DEB_W    = 16;
    localparam int MASK_W   = 64;
    localparam int CFG_IDX_W = 3;

    // Default number of buttons
    localparam int BUTTONS_DEF = 8;

    // Buttons with a special meaning
    localparam int BTN_HOME = 3;
    localparam int BTN_UP   = 4;
    localparam int BTN_DOWN = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIMPLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIMPLE_UP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIMPLE_DN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOME      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AVAIL     = 3'd6;

    // Register reset values
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE = 16'd50;
    localparam logic [CHAN_W-1:0] RST_HOME     = 6'd0;
    localparam logic [CHAN_W-1:0] RST_MAX      = 6'd15;

    // Configuration as seen by the control logic
    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ms;
        logic              simple_mode;
        logic [CHAN_W-1:0] simple_up_channel;
        logic [CHAN_W-1:0] simple_down_channel;
        logic [CHAN_W-1:0] home_chan;
        logic [CHAN_W-1:0] max_channel;
        logic [MASK_W-1:0] available_mask;
    } t_cfg;

endpackage

>>> design/bdcs_cfg_regs.sv
// Configuration register file with a plain write port.
module bdcs_cfg_regs
    import bdcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MASK_W-1:0]    i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Decode the index and update one register per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms         <= RST_DEBOUNCE;
            r_cfg.simple_mode         <= 1'b0;
            r_cfg.simple_up_channel   <= '0;
            r_cfg.simple_down_channel <= '0;
            r_cfg.home_chan           <= RST_HOME;
            r_cfg.max_channel         <= RST_MAX;
            r_cfg.available_mask      <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE:  r_cfg.debounce_ms         <= i_cfg_wdata[DEB_W-1:0];
                REG_SIMPLE:    r_cfg.simple_mode         <= i_cfg_wdata[0];
                REG_SIMPLE_UP: r_cfg.simple_up_channel   <= i_cfg_wdata[CHAN_W-1:0];
                REG_SIMPLE_DN: r_cfg.simple_down_channel <= i_cfg_wdata[CHAN_W-1:0];
                REG_HOME:      r_cfg.home_chan           <= i_cfg_wdata[CHAN_W-1:0];
                REG_MAX:       r_cfg.max_channel         <= i_cfg_wdata[CHAN_W-1:0];
                REG_AVAIL:     r_cfg.available_mask      <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/bdcs_time_mem.sv
// Per-button change time memory, one read and one write port, valid bits for reset.
module bdcs_time_mem
    import bdcs_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_re,
    input  logic [$clog2(BUTTONS)-1:0] i_raddr,
    input  logic                       i_we,
    input  logic [$clog2(BUTTONS)-1:0] i_waddr,
    input  logic [TIME_W-1:0]          i_wdata,
    output logic [TIME_W-1:0]          o_rdata
);

    logic [TIME_W-1:0] r_mem [BUTTONS];
    logic [BUTTONS-1:0] r_valid;
    logic [TIME_W-1:0] r_rdata;
    logic               r_rvalid;

    // Store and fetch entries
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

>>> design/bdcs_chan_step.sv
// One try of the channel step search: move by one, wrap between home and max.
module bdcs_chan_step
    import bdcs_pkg::*;
(
    input  logic [CHAN_W-1:0] i_cur,
    input  logic              i_down,
    input  logic [CHAN_W-1:0] i_home,
    input  logic [CHAN_W-1:0] i_max,
    input  logic [MASK_W-1:0] i_mask,
    output logic [CHAN_W-1:0] o_next,
    output logic              o_hit
);

    logic signed [CHAN_W+1:0] cand;
    logic signed [CHAN_W+1:0] home_s;
    logic signed [CHAN_W+1:0] max_s;
    logic signed [CHAN_W+1:0] wrapped;

    // Step, then apply the low bound check before the high one
    always_comb begin
        home_s  = $signed({2'b00, i_home});
        max_s   = $signed({2'b00, i_max});
        cand    = $signed({2'b00, i_cur}) + (i_down ? -8'sd1 : 8'sd1);
        wrapped = cand;
        if (wrapped < home_s) begin
            wrapped = max_s;
        end
        if (wrapped > max_s) begin
            wrapped = home_s;
        end
    end

    assign o_next = wrapped[CHAN_W-1:0];
    assign o_hit  = i_mask[o_next];

endmodule

>>> design/button_debounce_channel_stepper_top.sv
// Top level: scan sequencer, debounce evaluation, press decode and result output.
//
//  channel   ports              fields (low bit up)
//  scan in   i_s_axis_*         tdata: button_levels[7:0], now_ms[39:8]
//  press out o_m_axis_*         tdata: channel[5:0], zero[7:6]; tlast: last
//  config    i_cfg_*            idx 0..6, data up to 64 bits
//
// A scan takes an accept step, then one evaluation step per button (BUTTONS in all)
// while the change time memory supplies each entry, plus one push step per press, plus
// up to BUTTONS tries for each step search (one try a cycle), plus a closing step.
// Reset clears the memory's valid bits at once; no clearing pass is needed.
// A stalled output holds the sequencer in its push or closing step; the input is
// taken again once the last press of the previous scan sits in the output register.
module button_debounce_channel_stepper_top
    import bdcs_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // scan input
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [39:0]          i_s_axis_tdata,   // button_levels[7:0], now_ms[39:8]
    // press output
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,   // channel[5:0], zero[7:6]
    output logic                 o_m_axis_tlast,
    // configuration
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MASK_W-1:0]    i_cfg_wdata
);

    localparam int IW = $clog2(BUTTONS);
    localparam logic [IW-1:0] LAST_IDX = IW'(BUTTONS - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_PUSH   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_cfg cfg;

    t_state            r_state, n_state;
    logic [LEVEL_W-1:0] r_levels, n_levels;
    logic [TIME_W-1:0] r_now, n_now;
    logic [LEVEL_W-1:0] r_prev, n_prev;
    logic [LEVEL_W-1:0] r_stable, n_stable;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_tries, n_tries;
    logic              r_down, n_down;
    logic [CHAN_W-1:0] r_cur, n_cur;
    logic [CHAN_W-1:0] r_new_chan, n_new_chan;
    logic              r_pend_valid, n_pend_valid;
    logic [CHAN_W-1:0] r_pend_chan, n_pend_chan;
    logic              r_out_valid, n_out_valid;
    logic [CHAN_W-1:0] r_out_chan, n_out_chan;
    logic              r_out_last, n_out_last;

    logic              mem_re;
    logic [IW-1:0]     mem_raddr;
    logic              mem_we;
    logic [TIME_W-1:0] mem_rdata;

    logic [CHAN_W-1:0] step_next;
    logic              step_hit;

    logic              rd_bit, pv_bit, st_bit;
    logic              changed, settle, advance, out_free;
    logic [TIME_W-1:0] elapsed;

    // Level bit of a button; buttons past the eight inputs read low
    function automatic logic lvl_bit(input logic [LEVEL_W-1:0] v, input logic [IW-1:0] i);
        logic b;
        b = 1'b0;
        if (32'(i) < LEVEL_W) begin
            b = v[i[2:0]];
        end
        return b;
    endfunction

    bdcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bdcs_time_mem #(
        .BUTTONS (BUTTONS)
    ) u_time_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (r_now),
        .o_rdata (mem_rdata)
    );

    bdcs_chan_step u_step (
        .i_cur  (r_cur),
        .i_down (r_down),
        .i_home (cfg.home_chan),
        .i_max  (cfg.max_channel),
        .i_mask (cfg.available_mask),
        .o_next (step_next),
        .o_hit  (step_hit)
    );

    // Per-button debounce terms for the entry now on the memory output
    assign rd_bit   = lvl_bit(r_levels, r_idx);
    assign pv_bit   = lvl_bit(r_prev, r_idx);
    assign st_bit   = lvl_bit(r_stable, r_idx);
    assign changed  = rd_bit != pv_bit;
    assign elapsed  = r_now - mem_rdata;
    assign settle   = !changed && (elapsed > {{(TIME_W-DEB_W){1'b0}}, cfg.debounce_ms})
                      && (rd_bit != st_bit);
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Sequencer: read and evaluate each button's change time, writing it back on a level change
    always_comb begin
        n_state      = r_state;
        n_levels     = r_levels;
        n_now        = r_now;
        n_prev       = r_prev;
        n_stable     = r_stable;
        n_idx        = r_idx;
        n_tries      = r_tries;
        n_down       = r_down;
        n_cur        = r_cur;
        n_new_chan   = r_new_chan;
        n_pend_valid = r_pend_valid;
        n_pend_chan  = r_pend_chan;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_chan   = r_out_chan;
        n_out_last   = r_out_last;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        mem_we       = 1'b0;
        advance      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_levels  = i_s_axis_tdata[LEVEL_W-1:0];
                    n_now     = i_s_axis_tdata[LEVEL_W +: TIME_W];
                    n_idx     = '0;
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                    n_state   = S_EVAL;
                end
            end
            S_EVAL: begin
                // Restart the timer on a level change
                mem_we = changed;
                if (settle) begin
                    n_stable[r_idx[2:0]] = rd_bit;
                end
                if (settle && rd_bit) begin
                    if (r_idx == IW'(BTN_HOME)) begin
                        n_cur      = cfg.home_chan;
                        n_new_chan = cfg.home_chan;
                        n_state    = S_PUSH;
                    end else if (r_idx == IW'(BTN_UP) || r_idx == IW'(BTN_DOWN)) begin
                        if (cfg.simple_mode) begin
                            n_cur      = (r_idx == IW'(BTN_UP)) ? cfg.simple_up_channel
                                                                : cfg.simple_down_channel;
                            n_new_chan = n_cur;
                            n_state    = S_PUSH;
                        end else begin
                            n_down  = r_idx == IW'(BTN_DOWN);
                            n_tries = '0;
                            n_state = S_SEARCH;
                        end
                    end else begin
                        n_new_chan = {{(CHAN_W-IW){1'b0}}, r_idx};
                        n_state    = S_PUSH;
                    end
                end else begin
                    advance = 1'b1;
                end
            end
            S_SEARCH: begin
                // One try a cycle; stop on an available channel or after the last try
                n_cur = step_next;
                if (step_hit || r_tries == LAST_IDX) begin
                    n_new_chan = step_next;
                    n_state    = S_PUSH;
                end else begin
                    n_tries = r_tries + 1'b1;
                end
            end
            S_PUSH: begin
                // Hold the newest press back until it is known whether it ends the scan
                if (!r_pend_valid) begin
                    n_pend_valid = 1'b1;
                    n_pend_chan  = r_new_chan;
                    advance      = 1'b1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_chan  = r_pend_chan;
                    n_out_last  = 1'b0;
                    n_pend_chan = r_new_chan;
                    advance     = 1'b1;
                end
            end
            S_FINISH: begin
                n_prev = r_levels;
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_chan   = r_pend_chan;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Move on to the next button or close the scan
        if (advance) begin
            if (r_idx == LAST_IDX) begin
                n_state = S_FINISH;
            end else begin
                n_idx     = r_idx + 1'b1;
                mem_re    = 1'b1;
                mem_raddr = r_idx + 1'b1;
                n_state   = S_EVAL;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev       <= '0;
            r_stable     <= '0;
            r_cur        <= RST_HOME;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev       <= n_prev;
            r_stable     <= n_stable;
            r_cur        <= n_cur;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_levels    <= n_levels;
        r_now       <= n_now;
        r_idx       <= n_idx;
        r_tries     <= n_tries;
        r_down      <= n_down;
        r_new_chan  <= n_new_chan;
        r_pend_chan <= n_pend_chan;
        r_out_chan  <= n_out_chan;
        r_out_last  <= n_out_last;
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(8-CHAN_W){1'b0}}, r_out_chan};
    assign o_m_axis_tlast  = r_out_last;

endmodule
